>>> sv/assert_macros.svh
// Assertion macros shared by the arbiter RTL.
// Each macro expects clk and arst_n in scope of the including module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define ASSERT_SAME(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("arbiter assertion failed");

// Next-cycle implication, checked outside reset.
`define ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("arbiter assertion failed");

`endif

>>> sv/rrta_pkg.sv
// Shared constants for the round-robin task arbiter.
// No dependencies; imported by the top level.
`default_nettype none

package rrta_pkg;

	localparam int MAX_QUEUES_DEF  = 16;
	localparam int COUNT_WIDTH_DEF = 8;

	localparam int KIND_W   = 2;
	localparam int QIDX_W   = 4;
	localparam int QCNT_W   = 5;
	localparam int MASK_W   = 16;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DAT_W = 16;

	localparam logic [KIND_W-1:0] KIND_REQUEST = 2'd0;
	localparam logic [KIND_W-1:0] KIND_RETIRE  = 2'd1;
	localparam logic [KIND_W-1:0] KIND_NOTICE  = 2'd2;

	localparam logic [CFG_IDX_W-1:0] REG_QUEUE_COUNT   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PARALLEL_MASK = 2'd1;

endpackage

`default_nettype wire

>>> sv/rrta_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module rrta_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     ren,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (ren) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

>>> sv/round_robin_task_arbiter_top.sv
// Round-robin task arbiter: queue occupancy, check-in and rotating grant scan.
// Depends on rrta_pkg, rrta_ram and assert_macros.svh.
//
//   channel  | handshake              | payload
//   ---------+------------------------+----------------------------------------------
//   in       | in_valid / in_stall    | kind, has_assignment, queue_index, keep_going
//   out      | out_valid / out_stall  | granted, grant_index, deactivated,
//            |                        | deactivated_index
//   cfg      | cfg_valid / cfg_ready  | cfg_index, cfg_data
//
// A keep-going request, a notice, a retire without check-in or an unknown kind goes straight
// to the finish step; a retire with check-in reads and writes back its count; a scan
// request, after any check-in, visits k (1..queue count) queues, one per cycle on the
// single count RAM read port. out_stall holds the finish step; in_stall stays high
// until the result is loaded into the output register, then the next request enters.
// Reset clears all control state, counts (via valid bits) and finished flags.
`default_nettype none
`include "assert_macros.svh"

module round_robin_task_arbiter_top #(
	parameter int MAX_QUEUES  = rrta_pkg::MAX_QUEUES_DEF,
	parameter int COUNT_WIDTH = rrta_pkg::COUNT_WIDTH_DEF
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	// request channel
	input  wire logic                           in_valid,
	output logic                                in_stall,
	input  wire logic [rrta_pkg::KIND_W-1:0]    kind,
	input  wire logic                           has_assignment,
	input  wire logic [rrta_pkg::QIDX_W-1:0]    queue_index,
	input  wire logic                           keep_going,
	// result channel
	output logic                                out_valid,
	input  wire logic                           out_stall,
	output logic                                granted,
	output logic      [rrta_pkg::QIDX_W-1:0]    grant_index,
	output logic                                deactivated,
	output logic      [rrta_pkg::QIDX_W-1:0]    deactivated_index,
	// configuration channel
	input  wire logic                           cfg_valid,
	output logic                                cfg_ready,
	input  wire logic [rrta_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [rrta_pkg::CFG_DAT_W-1:0] cfg_data
);
	import rrta_pkg::*;

	localparam int QW = $clog2(MAX_QUEUES);
	localparam int NW = $clog2(MAX_QUEUES + 1);
	localparam int CW = (NW > QCNT_W) ? NW : QCNT_W;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CI_RD,
		ST_CI_WR,
		ST_SC_RD,
		ST_EVAL,
		ST_FINISH
	} state_t;

	state_t state_q;

	logic [QCNT_W-1:0]     queue_count_q;
	logic [MASK_W-1:0]     parallel_mask_q;
	logic [MAX_QUEUES-1:0] finished_q;
	logic [MAX_QUEUES-1:0] cnt_vld_q;
	logic [QW-1:0]         scan_ptr_q;
	logic [QW-1:0]         cand_q;
	logic [NW-1:0]         tries_q;
	logic [QIDX_W-1:0]     item_q_q;
	logic                  is_req_q;

	logic                  res_granted_q;
	logic [QIDX_W-1:0]     res_gidx_q;
	logic                  res_deact_q;
	logic [QIDX_W-1:0]     res_didx_q;

	logic                  out_valid_q;
	logic                  out_granted_q;
	logic [QIDX_W-1:0]     out_gidx_q;
	logic                  out_deact_q;
	logic [QIDX_W-1:0]     out_didx_q;

	// RAM port signals
	logic                   ram_we;
	logic [QW-1:0]          ram_waddr;
	logic [COUNT_WIDTH-1:0] ram_wdata;
	logic                   ram_ren;
	logic [QW-1:0]          ram_raddr;
	logic [COUNT_WIDTH-1:0] ram_rdata;

	// Derived values
	logic [CW-1:0]          qc_w;
	logic [NW-1:0]          n_used;
	logic [CW-1:0]          n_w;
	logic [CW-1:0]          in_q_w;
	logic                   in_q_ok;
	logic [QW-1:0]          in_idx;
	logic [CW-1:0]          item_w;
	logic [QW-1:0]          item_idx;
	logic [CW-1:0]          ptr_w;
	logic [QW-1:0]          start_idx;
	logic [CW-1:0]          cand_w;
	logic [CW-1:0]          cand_inc;
	logic [QW-1:0]          next_idx;
	logic                   cand_par;
	logic [COUNT_WIDTH-1:0] ci_cnt;
	logic [COUNT_WIDTH-1:0] ci_dec;
	logic [COUNT_WIDTH-1:0] ev_cnt;
	logic [COUNT_WIDTH-1:0] ev_inc;
	logic                   eligible;
	logic                   out_free;
	logic                   accept;

	assign accept    = in_valid && !in_stall;
	assign in_stall  = (state_q != ST_IDLE);
	assign cfg_ready = 1'b1;
	assign out_free  = !out_valid_q || !out_stall;

	assign out_valid         = out_valid_q;
	assign granted           = out_granted_q;
	assign grant_index       = out_gidx_q;
	assign deactivated       = out_deact_q;
	assign deactivated_index = out_didx_q;

	// queue count clamped to 1..MAX_QUEUES
	always_comb begin
		qc_w = CW'(queue_count_q);
		if (qc_w == '0) begin
			n_w = CW'(1);
		end else if (qc_w > CW'(MAX_QUEUES)) begin
			n_w = CW'(MAX_QUEUES);
		end else begin
			n_w = qc_w;
		end
		n_used = n_w[NW-1:0];
	end

	always_comb begin
		in_q_w   = CW'(queue_index);
		in_q_ok  = (in_q_w < n_w);
		in_idx   = in_q_w[QW-1:0];
		item_w   = CW'(item_q_q);
		item_idx = item_w[QW-1:0];
		ptr_w    = CW'(scan_ptr_q);
		start_idx = (ptr_w < n_w) ? scan_ptr_q : '0;
		cand_w   = CW'(cand_q);
		cand_inc = cand_w + CW'(1);
		next_idx = (cand_inc >= n_w) ? '0 : cand_inc[QW-1:0];
		cand_par = (cand_w < CW'(MASK_W)) && parallel_mask_q[cand_w[QIDX_W-1:0]];
	end

	// count arithmetic: saturating decrement at check-in, increment at grant
	always_comb begin
		ci_cnt   = cnt_vld_q[item_idx] ? ram_rdata : '0;
		ci_dec   = (ci_cnt != '0) ? ci_cnt - COUNT_WIDTH'(1) : ci_cnt;
		ev_cnt   = cnt_vld_q[cand_q] ? ram_rdata : '0;
		ev_inc   = (ev_cnt != '1) ? ev_cnt + COUNT_WIDTH'(1) : ev_cnt;
		eligible = !finished_q[cand_q] && (cand_par || ev_cnt == '0);
	end

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = item_idx;
		ram_wdata = ci_dec;
		ram_ren   = 1'b0;
		ram_raddr = item_idx;
		unique case (state_q)
			ST_CI_RD: begin
				ram_ren = 1'b1;
			end
			ST_CI_WR: begin
				ram_we = 1'b1;
			end
			ST_SC_RD: begin
				ram_ren   = 1'b1;
				ram_raddr = start_idx;
			end
			ST_EVAL: begin
				ram_waddr = cand_q;
				ram_wdata = ev_inc;
				ram_raddr = next_idx;
				if (eligible) begin
					ram_we = 1'b1;
				end else if (tries_q != n_used - NW'(1)) begin
					ram_ren = 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	rrta_ram #(
		.WIDTH(COUNT_WIDTH),
		.DEPTH(MAX_QUEUES)
	) u_counts (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.ren  (ram_ren),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			queue_count_q   <= QCNT_W'(1);
			parallel_mask_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			if (cfg_index == REG_QUEUE_COUNT) begin
				queue_count_q <= cfg_data[QCNT_W-1:0];
			end else if (cfg_index == REG_PARALLEL_MASK) begin
				parallel_mask_q <= cfg_data[MASK_W-1:0];
			end
		end
	end

	// sequencer, queue state and result registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			finished_q    <= '0;
			cnt_vld_q     <= '0;
			scan_ptr_q    <= '0;
			cand_q        <= '0;
			tries_q       <= '0;
			item_q_q      <= '0;
			is_req_q      <= 1'b0;
			res_granted_q <= 1'b0;
			res_gidx_q    <= '0;
			res_deact_q   <= 1'b0;
			res_didx_q    <= '0;
			out_valid_q   <= 1'b0;
			out_granted_q <= 1'b0;
			out_gidx_q    <= '0;
			out_deact_q   <= 1'b0;
			out_didx_q    <= '0;
		end else begin
			if (ram_we) begin
				cnt_vld_q[ram_waddr] <= 1'b1;
			end

			if (state_q == ST_FINISH && out_free) begin
				out_valid_q   <= 1'b1;
				out_granted_q <= res_granted_q;
				out_gidx_q    <= res_gidx_q;
				out_deact_q   <= res_deact_q;
				out_didx_q    <= res_didx_q;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end

			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						item_q_q      <= queue_index;
						is_req_q      <= (kind == KIND_REQUEST);
						res_granted_q <= 1'b0;
						res_gidx_q    <= '0;
						res_deact_q   <= 1'b0;
						res_didx_q    <= '0;
						case (kind)
							KIND_REQUEST: begin
								if (keep_going && has_assignment) begin
									// keep-going: same queue back, no state change
									res_granted_q <= 1'b1;
									res_gidx_q    <= queue_index;
									state_q       <= ST_FINISH;
								end else if (has_assignment && in_q_ok) begin
									state_q <= ST_CI_RD;
								end else begin
									state_q <= ST_SC_RD;
								end
							end
							KIND_RETIRE: begin
								state_q <= (has_assignment && in_q_ok) ? ST_CI_RD : ST_FINISH;
							end
							KIND_NOTICE: begin
								if (in_q_ok) begin
									finished_q[in_idx] <= 1'b1;
								end
								state_q <= ST_FINISH;
							end
							default: begin
								state_q <= ST_FINISH;
							end
						endcase
					end
				end
				ST_CI_RD: begin
					state_q <= ST_CI_WR;
				end
				ST_CI_WR: begin
					if (is_req_q) begin
						if (finished_q[item_idx] && ci_dec == '0) begin
							res_deact_q <= 1'b1;
							res_didx_q  <= item_q_q;
						end
						state_q <= ST_SC_RD;
					end else begin
						state_q <= ST_FINISH;
					end
				end
				ST_SC_RD: begin
					cand_q  <= start_idx;
					tries_q <= '0;
					state_q <= ST_EVAL;
				end
				ST_EVAL: begin
					if (eligible) begin
						scan_ptr_q    <= next_idx;
						res_granted_q <= 1'b1;
						res_gidx_q    <= cand_w[QIDX_W-1:0];
						state_q       <= ST_FINISH;
					end else if (tries_q == n_used - NW'(1)) begin
						// every queue visited, nothing to grant
						state_q <= ST_FINISH;
					end else begin
						cand_q  <= next_idx;
						tries_q <= tries_q + NW'(1);
					end
				end
				ST_FINISH: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// the scan never visits more queues than are in use
	`ASSERT_SAME(a_scan_bound, state_q == ST_EVAL, tries_q < n_used)
	// a count write always marks its entry as holding real data
	`ASSERT_NEXT(a_cnt_valid, ram_we, cnt_vld_q[$past(ram_waddr)])
	// a new result appears only out of the finish step
	`ASSERT_SAME(a_out_source, $rose(out_valid_q), $past(state_q == ST_FINISH))

endmodule

`default_nettype wire
